// ===== design/dtmf_tone_generator_top_assert.svh =====
// Assertion macros for the DTMF tone generator.
`ifndef DTMF_TONE_GENERATOR_TOP_ASSERT_SVH
`define DTMF_TONE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DTMF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtmf: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DTMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtmf: next-cycle check failed");

`endif

// ===== design/dtmf_pkg.sv =====
// Package: key codes, key decoder, step register defaults and sine table math.
`default_nettype none
package dtmf_pkg;

   localparam int STEP_BITS      = 24;
   localparam int NUM_STEPS      = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int SINE_BITS      = 16;

   localparam logic [STEP_BITS-1:0] STEP_RESET [NUM_STEPS] = '{
      24'd2535457, 24'd2801795, 24'd3097494, 24'd3424649,
      24'd1461715, 24'd1614807, 24'd1786774, 24'd1973420
   };

   // ASCII key codes
   localparam logic [7:0] KEY_0     = 8'h30;
   localparam logic [7:0] KEY_1     = 8'h31;
   localparam logic [7:0] KEY_2     = 8'h32;
   localparam logic [7:0] KEY_3     = 8'h33;
   localparam logic [7:0] KEY_4     = 8'h34;
   localparam logic [7:0] KEY_5     = 8'h35;
   localparam logic [7:0] KEY_6     = 8'h36;
   localparam logic [7:0] KEY_7     = 8'h37;
   localparam logic [7:0] KEY_8     = 8'h38;
   localparam logic [7:0] KEY_9     = 8'h39;
   localparam logic [7:0] KEY_A     = 8'h41;
   localparam logic [7:0] KEY_B     = 8'h42;
   localparam logic [7:0] KEY_C     = 8'h43;
   localparam logic [7:0] KEY_D     = 8'h44;
   localparam logic [7:0] KEY_STAR  = 8'h2A;
   localparam logic [7:0] KEY_POUND = 8'h23;

   // Mix: 128*sh + 104*sl + 128*163840
   localparam logic signed [26:0] MIX_LO_GAIN = 27'sd104;
   localparam logic signed [26:0] MIX_OFFSET  = 27'sd20971520;
   // floor(v / 5) as (v * 205) >> 10, exact for v below 1024
   localparam logic [19:0] DIV5_RECIP = 20'd205;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic       ok;
      logic [1:0] col;
      logic [1:0] row;
   } key_dec_type;

   function automatic key_dec_type decode_key(input logic [7:0] key);
      key_dec_type d;
      d = '{ok: 1'b1, col: 2'd0, row: 2'd0};
      unique case (key)
         KEY_1:     begin d.col = 2'd0; d.row = 2'd0; end
         KEY_2:     begin d.col = 2'd1; d.row = 2'd0; end
         KEY_3:     begin d.col = 2'd2; d.row = 2'd0; end
         KEY_A:     begin d.col = 2'd3; d.row = 2'd0; end
         KEY_4:     begin d.col = 2'd0; d.row = 2'd1; end
         KEY_5:     begin d.col = 2'd1; d.row = 2'd1; end
         KEY_6:     begin d.col = 2'd2; d.row = 2'd1; end
         KEY_B:     begin d.col = 2'd3; d.row = 2'd1; end
         KEY_7:     begin d.col = 2'd0; d.row = 2'd2; end
         KEY_8:     begin d.col = 2'd1; d.row = 2'd2; end
         KEY_9:     begin d.col = 2'd2; d.row = 2'd2; end
         KEY_C:     begin d.col = 2'd3; d.row = 2'd2; end
         KEY_STAR:  begin d.col = 2'd0; d.row = 2'd3; end
         KEY_0:     begin d.col = 2'd1; d.row = 2'd3; end
         KEY_POUND: begin d.col = 2'd2; d.row = 2'd3; end
         KEY_D:     begin d.col = 2'd3; d.row = 2'd3; end
         default:   d.ok = 1'b0;
      endcase
      return d;
   endfunction

   // Quarter-wave sine of m steps, Q15, by a degree-11 Taylor series in Q30.
   // Used only to build the table at elaboration.
   function automatic logic [14:0] quarter_sine(input int unsigned m,
                                                input int unsigned addr_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] p;
      logic [63:0] s;
      x  = (64'(m) * HALF_PI_Q30) >> (addr_bits - 2);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
         p = (x2 * t) >> 30;
         case (i)
            0:       p = p / 110;
            1:       p = p / 72;
            2:       p = p / 42;
            3:       p = p / 20;
            default: p = p / 6;
         endcase
         t = Q30_ONE - p;
      end
      s = (x * t) >> 30;
      s = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[14:0];
   endfunction

endpackage
`default_nettype wire

// ===== design/dtmf_req_if.sv =====
// Interface: key request channel (valid/ready with key code and first-sample flag).
`default_nettype none
interface dtmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_code;
   logic       first_sample;

   modport source (output valid, output key_code, output first_sample, input ready);
   modport sink   (input valid, input key_code, input first_sample, output ready);
endinterface
`default_nettype wire

// ===== design/dtmf_rsp_if.sv =====
// Interface: sample response channel (valid/ready with sample and bad-key flag).
`default_nettype none
interface dtmf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   logic       bad_key;

   modport source (output valid, output sample, output bad_key, input ready);
   modport sink   (input valid, input sample, input bad_key, output ready);
endinterface
`default_nettype wire

// ===== design/dtmf_sine_rom.sv =====
// Two-port registered sine lookup built on a quarter-wave table.
`default_nettype none
module dtmf_sine_rom import dtmf_pkg::*; #(
   parameter int ADDR_BITS = 10
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [ADDR_BITS-1:0]        addr_a,
   input  logic [ADDR_BITS-1:0]        addr_b,
   output logic signed [SINE_BITS-1:0] sine_a,
   output logic signed [SINE_BITS-1:0] sine_b
);

   localparam int IDX_BITS = ADDR_BITS - 1;
   localparam int QUARTER  = 1 << (ADDR_BITS - 2);
   localparam logic [IDX_BITS-1:0] QUARTER_IDX = IDX_BITS'(QUARTER);

   typedef logic [14:0] sine_tab_type [QUARTER+1];

   function automatic sine_tab_type build_table();
      sine_tab_type tab;
      for (int k = 0; k <= QUARTER; k++) begin
         tab[k] = quarter_sine(k, ADDR_BITS);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TABLE = build_table();

   logic [IDX_BITS-1:0] idx_a;
   logic [IDX_BITS-1:0] idx_b;
   logic [14:0]         mag_a_ff;
   logic [14:0]         mag_b_ff;
   logic                neg_a_ff;
   logic                neg_b_ff;

   // Mirror odd quadrants, negate the second half.
   always_comb begin
      idx_a = IDX_BITS'(addr_a[ADDR_BITS-3:0]);
      idx_b = IDX_BITS'(addr_b[ADDR_BITS-3:0]);
      if (addr_a[ADDR_BITS-2]) begin
         idx_a = QUARTER_IDX - idx_a;
      end
      if (addr_b[ADDR_BITS-2]) begin
         idx_b = QUARTER_IDX - idx_b;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mag_a_ff <= SINE_TABLE[idx_a];
         mag_b_ff <= SINE_TABLE[idx_b];
         neg_a_ff <= addr_a[ADDR_BITS-1];
         neg_b_ff <= addr_b[ADDR_BITS-1];
      end
   end

   assign sine_a = neg_a_ff ? -$signed({1'b0, mag_a_ff}) : $signed({1'b0, mag_a_ff});
   assign sine_b = neg_b_ff ? -$signed({1'b0, mag_b_ff}) : $signed({1'b0, mag_b_ff});

endmodule
`default_nettype wire

// ===== design/dtmf_tone_generator_top.sv =====
// Top level of the DTMF dual-tone generator: phase accumulators, lookup and mix.
// Throughput: one beat per cycle; the stage chain stalls only on rsp ready.
// Stages: key decode and phase step, sine table read, mix sum, divide-by-5 out.
// Reset (synchronous, active high): clears stage valids, both phases, and
// reloads the eight step registers with their default tone steps.
`default_nettype none
`include "dtmf_tone_generator_top_assert.svh"
module dtmf_tone_generator_top import dtmf_pkg::*; #(
   parameter int PHASE_BITS     = 24,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   dtmf_req_if.sink                  req_bus,
   dtmf_rsp_if.source                rsp_bus,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [STEP_BITS-1:0]      csr_wdata
);

   // Step registers: columns at 0..3, rows at 4..7
   logic [STEP_BITS-1:0] step_ff [NUM_STEPS];

   logic [PHASE_BITS-1:0] hi_phase_ff;
   logic [PHASE_BITS-1:0] lo_phase_ff;
   logic [PHASE_BITS-1:0] hi_base;
   logic [PHASE_BITS-1:0] lo_base;
   logic [PHASE_BITS-1:0] hi_phase_in;
   logic [PHASE_BITS-1:0] lo_phase_in;

   key_dec_type key;
   logic        accept;

   // Pipeline control
   logic s1_en, s2_en, s3_en, out_en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_bad_ff, s2_bad_ff, s3_bad_ff, rsp_bad_ff;

   logic [SINE_ADDR_BITS-1:0] s1_hi_addr_ff;
   logic [SINE_ADDR_BITS-1:0] s1_lo_addr_ff;

   logic signed [SINE_BITS-1:0] hi_sine;
   logic signed [SINE_BITS-1:0] lo_sine;
   logic signed [26:0]          mix_sum;
   logic [9:0]                  s3_quot_ff;
   logic [19:0]                 div_prod;
   logic [7:0]                  rsp_sample_ff;

   // Each stage moves when it is empty or its successor moves.
   assign out_en = !rsp_valid_ff || rsp_bus.ready;
   assign s3_en  = !s3_valid_ff || out_en;
   assign s2_en  = !s2_valid_ff || s3_en;
   assign s1_en  = !s1_valid_ff || s2_en;

   assign req_bus.ready = s1_en;
   assign accept        = req_bus.valid && s1_en;

   // ---- Configuration: write any step register at any time the block idles
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STEPS; i++) begin
            step_ff[i] <= STEP_RESET[i];
         end
      end else if (csr_wr_en) begin
         step_ff[csr_index] <= csr_wdata;
      end
   end

   // ---- Stage 1: decode key, pick phases, advance accumulators
   always_comb begin
      key         = decode_key(req_bus.key_code);
      // A first-sample beat uses phase zero and steps from there.
      hi_base     = req_bus.first_sample ? '0 : hi_phase_ff;
      lo_base     = req_bus.first_sample ? '0 : lo_phase_ff;
      hi_phase_in = hi_base + PHASE_BITS'(step_ff[{1'b0, key.col}]);
      lo_phase_in = lo_base + PHASE_BITS'(step_ff[{1'b1, key.row}]);
   end

   // Bad keys leave both phases untouched and ignore first_sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_phase_ff <= '0;
         lo_phase_ff <= '0;
      end else if (accept && key.ok) begin
         hi_phase_ff <= hi_phase_in;
         lo_phase_ff <= lo_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_bad_ff     <= !key.ok;
         s1_hi_addr_ff <= hi_base[PHASE_BITS-1 -: SINE_ADDR_BITS];
         s1_lo_addr_ff <= lo_base[PHASE_BITS-1 -: SINE_ADDR_BITS];
      end
   end

   // ---- Stage 2: registered sine lookup for both tones
   dtmf_sine_rom #(
      .ADDR_BITS (SINE_ADDR_BITS)
   ) u_sine_rom (
      .clock  (clock),
      .rd_en  (s2_en),
      .addr_a (s1_hi_addr_ff),
      .addr_b (s1_lo_addr_ff),
      .sine_a (hi_sine),
      .sine_b (lo_sine)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_bad_ff <= s1_bad_ff;
      end
   end

   // ---- Stage 3: weighted sum; always positive and below 2^25
   assign mix_sum = (27'(hi_sine) <<< 7) + 27'(lo_sine) * MIX_LO_GAIN + MIX_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Divide by 163840 = 32768 * 5: drop 15 bits here, divide by 5 next.
   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_bad_ff  <= s2_bad_ff;
         s3_quot_ff <= mix_sum[24:15];
      end
   end

   // ---- Output register: finish the divide by 5, zero the sample on bad keys
   assign div_prod = 20'(s3_quot_ff) * DIV5_RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_bad_ff    <= s3_bad_ff;
         rsp_sample_ff <= s3_bad_ff ? 8'd0 : div_prod[17:10];
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.sample  = rsp_sample_ff;
   assign rsp_bus.bad_key = rsp_bad_ff;

   // ---- Checks
   logic sample_in_range;
   logic bad_accept;
   logic first_accept;
   logic s1_at_zero;

   assign sample_in_range = rsp_sample_ff >= 8'd81 && rsp_sample_ff <= 8'd174;
   assign bad_accept      = accept && !key.ok;
   assign first_accept    = accept && key.ok && req_bus.first_sample;
   assign s1_at_zero      = s1_valid_ff && s1_hi_addr_ff == '0 && s1_lo_addr_ff == '0;

   // Good samples stay inside the mix range, so no saturation is needed.
   `DTMF_ASSERT_NOW(a_sample_range, clock, reset, rsp_valid_ff && !rsp_bad_ff, sample_in_range)
   // A bad key must not move either phase.
   `DTMF_ASSERT_NEXT(a_bad_key_hold, clock, reset, bad_accept, $stable({hi_phase_ff, lo_phase_ff}))
   // A first sample of a good key reads the table at phase zero.
   `DTMF_ASSERT_NEXT(a_first_zero, clock, reset, first_accept, s1_at_zero)
   // A bad-key beat carries a zero sample.
   `DTMF_ASSERT_NOW(a_bad_zero, clock, reset, rsp_valid_ff && rsp_bad_ff, rsp_sample_ff == 8'd0)

endmodule
`default_nettype wire

// ===== tb/dtmf_tone_generator_top_tb.sv =====
// Testbench for the DTMF dual-tone generator: directed and random keyed tones checked against a local model.
`default_nettype none
module dtmf_tone_generator_top_tb;
   import dtmf_pkg::*;

   localparam int PHASE_W      = 24;
   localparam int LUT_BITS     = 10;
   localparam int LUT_SIZE     = 1 << LUT_BITS;
   localparam int QUARTER_SIZE = LUT_SIZE / 4;
   localparam int HIGH_GAIN    = 128;
   localparam int LOW_GAIN     = 104;
   localparam int MIX_DIV      = 163840;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 120;

   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned QUARTER_ARC = 64'd1686629713;  // pi/2 in Q30

   // Step register map, in write-port index order
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_COL_STEP_0, REG_COL_STEP_1, REG_COL_STEP_2, REG_COL_STEP_3,
      REG_ROW_STEP_0, REG_ROW_STEP_1, REG_ROW_STEP_2, REG_ROW_STEP_3
   } step_reg_type;

   localparam logic [7:0] DIAL_KEYS [16] = '{
      KEY_1, KEY_2, KEY_3, KEY_A, KEY_4, KEY_5, KEY_6, KEY_B,
      KEY_7, KEY_8, KEY_9, KEY_C, KEY_STAR, KEY_0, KEY_POUND, KEY_D
   };

   typedef struct packed {
      logic [7:0] level;
      logic       bad;
   } tone_beat_type;

   // Tone model: step registers, both phase accumulators and the queue of
   // samples still owed by the block.
   class tone_scoreboard;
      logic [STEP_BITS-1:0] steps [NUM_STEPS];
      logic [PHASE_W-1:0]   high_phase;
      logic [PHASE_W-1:0]   low_phase;
      int                   sine_lut [LUT_SIZE];
      tone_beat_type        owed_q [$];
      int                   errors;

      function new();
         int quad;
         int m;
         int v;
         for (int k = 0; k < LUT_SIZE; k++) begin
            quad = (k / QUARTER_SIZE) % 4;
            m    = k % QUARTER_SIZE;
            v    = (quad % 2 == 1) ? quarter_wave(QUARTER_SIZE - m) : quarter_wave(m);
            sine_lut[k] = (quad >= 2) ? -v : v;
         end
         steps      = STEP_RESET;
         high_phase = '0;
         low_phase  = '0;
         errors     = 0;
      endfunction

      // Taylor series to degree 11 in Q30, rounded to Q15
      function int quarter_wave(int m);
         longint unsigned divs [5] = '{110, 72, 42, 20, 6};
         longint unsigned x;
         longint unsigned x2;
         longint unsigned t;
         longint unsigned s;
         x  = (longint'(m) * QUARTER_ARC) / QUARTER_SIZE;
         x2 = (x * x) >> 30;
         t  = ONE_Q30;
         foreach (divs[i]) t = ONE_Q30 - ((x2 * t) >> 30) / divs[i];
         s = ((x * t) >> 30);
         s = (s + 64'd16384) >> 15;
         if (s > 64'd32767) s = 64'd32767;
         return int'(s);
      endfunction

      function void set_step(int idx, logic [STEP_BITS-1:0] val);
         steps[idx] = val;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Work out the sample owed for one accepted request beat
      function void note_key(logic [7:0] key, logic first);
         tone_beat_type b;
         int            col;
         int            row;
         int            sh;
         int            sl;
         bit            ok;
         ok = 1'b1;
         col = 0;
         row = 0;
         case (key)
            KEY_1:     begin col = 0; row = 0; end
            KEY_2:     begin col = 1; row = 0; end
            KEY_3:     begin col = 2; row = 0; end
            KEY_A:     begin col = 3; row = 0; end
            KEY_4:     begin col = 0; row = 1; end
            KEY_5:     begin col = 1; row = 1; end
            KEY_6:     begin col = 2; row = 1; end
            KEY_B:     begin col = 3; row = 1; end
            KEY_7:     begin col = 0; row = 2; end
            KEY_8:     begin col = 1; row = 2; end
            KEY_9:     begin col = 2; row = 2; end
            KEY_C:     begin col = 3; row = 2; end
            KEY_STAR:  begin col = 0; row = 3; end
            KEY_0:     begin col = 1; row = 3; end
            KEY_POUND: begin col = 2; row = 3; end
            KEY_D:     begin col = 3; row = 3; end
            default:   ok = 1'b0;
         endcase
         if (!ok) begin
            b.level = 8'd0;
            b.bad   = 1'b1;
         end else begin
            if (first) begin
               high_phase = '0;
               low_phase  = '0;
            end
            sh = sine_lut[high_phase[PHASE_W-1 -: LUT_BITS]];
            sl = sine_lut[low_phase[PHASE_W-1 -: LUT_BITS]];
            b.level = 8'((HIGH_GAIN * sh + LOW_GAIN * sl + HIGH_GAIN * MIX_DIV) / MIX_DIV);
            b.bad   = 1'b0;
            high_phase = high_phase + PHASE_W'(steps[REG_COL_STEP_0 + col]);
            low_phase  = low_phase + PHASE_W'(steps[REG_ROW_STEP_0 + row]);
         end
         owed_q.push_back(b);
      endfunction

      function void check_beat(logic [7:0] level, logic bad);
         tone_beat_type b;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected rsp beat sample=%0d bad_key=%0b", $time, level, bad);
            errors++;
            return;
         end
         b = owed_q.pop_front();
         if (level !== b.level) begin
            $display("%0t: sample mismatch expected %0d actual %0d", $time, b.level, level);
            errors++;
         end
         if (bad !== b.bad) begin
            $display("%0t: bad_key mismatch expected %0b actual %0b", $time, b.bad, bad);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [STEP_BITS-1:0]      csr_wdata;

   dtmf_req_if req_bus ();
   dtmf_rsp_if rsp_bus ();

   dtmf_tone_generator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tone_scoreboard sb = new();

   int tx_idle_pct = 0;   // chance of a gap before each request beat
   int rx_idle_pct = 0;   // chance of a stall on the response side
   int rsp_beats   = 0;
   int cycles      = 0;

   initial begin
      clock = 1'b0;
   end
   always #4 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Watchdog: fail the run once the cycle counter reaches CYCLE_LIMIT, as when the block stops making progress
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("dtmf_tone_generator_top_tb: FAIL");
         $finish;
      end
   end

   // Response side: check each beat, then decide ready for the next edge.
   // Twice in the run, hold ready low long enough for the stage chain to
   // fill and push back on the request side.
   int rx_hold  = 0;
   int rx_stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_beat(rsp_bus.sample, rsp_bus.bad_key);
            rsp_beats++;
            if (rsp_beats == 150 || rsp_beats == 700) begin
               rx_hold = HOLD_CYCLES;
            end
         end
         // re-pick the stall rate now and then, so calm stretches occur
         if (cycles % 256 == 0) begin
            case ($urandom_range(0, 2))
               0:       rx_idle_pct = 0;
               1:       rx_idle_pct = 15;
               default: rx_idle_pct = 40;
            endcase
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rx_stall = idle_len() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one request beat, optionally after a gap; return once accepted
   task automatic send_key(input logic [7:0] key, input logic first);
      int gap;
      gap = ($urandom_range(0, 99) < tx_idle_pct) ? idle_len() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.key_code     <= key;
      req_bus.first_sample <= first;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_key(key, first);
   endtask

   // Drop valid and wait until every owed sample has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all eight step registers back to back; the block is idle here
   task automatic load_steps(input logic [STEP_BITS-1:0] vals [NUM_STEPS]);
      step_reg_type r;
      r = REG_COL_STEP_0;
      repeat (NUM_STEPS) begin
         csr_wr_en <= 1'b1;
         csr_index <= r;
         csr_wdata <= vals[r];
         @(posedge clock);
         sb.set_step(r, vals[r]);
         r = r.next();
      end
      csr_wr_en <= 1'b0;
   endtask

   // Mostly whole tones (first sample, then a run of the same key) with a
   // few key switches and stray bytes inside; the rest is pure noise.
   task automatic run_random(input int n);
      int         sent;
      int         len;
      int         r;
      logic [7:0] key;
      sent = 0;
      while (sent < n) begin
         case ($urandom_range(0, 2))
            0:       tx_idle_pct = 0;
            1:       tx_idle_pct = 10;
            default: tx_idle_pct = 35;
         endcase
         if ($urandom_range(0, 99) < 75) begin
            key = DIAL_KEYS[$urandom_range(0, 15)];
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 30);
            send_key(key, 1'b1);
            sent++;
            for (int i = 1; i < len; i++) begin
               r = $urandom_range(0, 99);
               if (r < 3) begin
                  send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                  sent++;
               end else if (r < 5) begin
                  key = DIAL_KEYS[$urandom_range(0, 15)];
               end
               send_key(key, 1'b0);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [STEP_BITS-1:0] vals [NUM_STEPS];

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.key_code     <= 8'd0;
      req_bus.first_sample <= 1'b0;
      csr_wr_en            <= 1'b0;
      csr_index            <= REG_COL_STEP_0;
      csr_wdata            <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every key at phase zero, then a short run, then invalid
      // keys, two carrying the first-sample flag, which must not clear the
      // phases of the tone in progress.
      foreach (DIAL_KEYS[i]) send_key(DIAL_KEYS[i], 1'b1);
      send_key(KEY_5, 1'b0);
      send_key(KEY_5, 1'b0);
      send_key(8'h00, 1'b1);
      send_key(KEY_5, 1'b0);
      send_key(8'hFF, 1'b0);
      send_key(8'h35 ^ 8'hFF, 1'b1);
      send_key(KEY_5, 1'b0);
      run_random(300);
      drain();

      // All steps zero: phases never move
      foreach (vals[i]) vals[i] = '0;
      load_steps(vals);
      run_random(150);
      drain();

      // All steps at full scale: phases wrap every sample
      foreach (vals[i]) vals[i] = '1;
      load_steps(vals);
      run_random(250);
      drain();

      // Random steps
      foreach (vals[i]) vals[i] = STEP_BITS'($urandom());
      load_steps(vals);
      run_random(250);
      drain();

      // Mixed: half turn, one LSB, quarter turn, one random step and the defaults on the rest
      vals = STEP_RESET;
      vals[REG_COL_STEP_0] = 24'h800000;
      vals[REG_COL_STEP_3] = 24'h000001;
      vals[REG_ROW_STEP_1] = 24'h400000;
      vals[REG_ROW_STEP_2] = STEP_BITS'($urandom());
      load_steps(vals);
      run_random(250);
      drain();

      if (sb.errors == 0) begin
         $display("dtmf_tone_generator_top_tb: PASS");
      end else begin
         $display("dtmf_tone_generator_top_tb: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/dtmf_pkg.sv
design/dtmf_req_if.sv
design/dtmf_rsp_if.sv
design/dtmf_sine_rom.sv
design/dtmf_tone_generator_top.sv
tb/dtmf_tone_generator_top_tb.sv
